// ===== hdl/tga_rle_packet_decoder_assert.svh =====
// Assertion macros for the TGA RLE decoder; used by tga_rle_queue.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef TGA_RLE_PACKET_DECODER_ASSERT_SVH
`define TGA_RLE_PACKET_DECODER_ASSERT_SVH

// same-cycle implication
`define TGA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tga_rle: assertion failed");

// next-cycle implication
`define TGA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tga_rle: assertion failed");

`endif

// ===== hdl/tga_rle_pkg.sv =====
// Shared types and constants for the TGA RLE packet decoder.
// No dependencies; used by tga_rle_front, tga_rle_queue and the top level.
`timescale 1ns / 1ps

package tga_rle_pkg;

  localparam int BYTE_W      = 8;
  localparam int PIXEL_W     = 32;
  localparam int COUNT_W     = 8;
  localparam int TOTAL_W     = 25;
  localparam int BPP_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 25;
  localparam int QUEUE_DEPTH = 2;

  localparam int RUN_BIT = 7;  // header bit 7: run packet

  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd1;
  localparam logic [BPP_W-1:0]   BPP_MAX     = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_PER_PIXEL = 2'd0,
    CFG_PIXEL_TOTAL     = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               image_done;
    logic               overrun;
  } token_t;

endpackage

// ===== hdl/tga_rle_packet_decoder.sv =====
// Top level of the TGA RLE packet decoder: front parser plus token queue.
// Depends on tga_rle_pkg, tga_rle_front and tga_rle_queue.
//
//   channel  ports                                         handshake
//   -------  --------------------------------------------  -----------------------
//   input    in_data_byte                                  push & !full
//   result   out_pixel_value/repeat_count/image_done/     pop & !empty
//            out_overrun
//   config   cfg_index, cfg_data                           cfg_valid & cfg_ready
//
// One byte is taken per clock while full is low; a pixel's token is written into the
// queue in the cycle its last byte arrives and can be popped from the cycle after.
// full rises only when QUEUE_DEPTH tokens wait unpopped; a consumer popping
// every cycle never stalls the byte stream.
// Synchronous active-low reset empties the queue, expects a header and loads
// bytes_per_pixel = 3, pixel_total = 1. cfg_ready is always high.
`timescale 1ns / 1ps

module tga_rle_packet_decoder #(
  parameter int QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [tga_rle_pkg::BYTE_W-1:0]      in_data_byte,
  output logic                                empty,
  input  logic                                pop,
  output logic [tga_rle_pkg::PIXEL_W-1:0]     out_pixel_value,
  output logic [tga_rle_pkg::COUNT_W-1:0]     out_repeat_count,
  output logic                                out_image_done,
  output logic                                out_overrun,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                accept;
  logic                tok_valid;
  tga_rle_pkg::token_t tok;
  tga_rle_pkg::token_t head;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  tga_rle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .data_byte_i (in_data_byte),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  tga_rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (tok_valid),
    .tok_i   (tok),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  assign out_pixel_value  = head.pixel_value;
  assign out_repeat_count = head.repeat_count;
  assign out_image_done   = head.image_done;
  assign out_overrun      = head.overrun;

endmodule

// ===== hdl/tga_rle_front.sv =====
// Front end: packet header parsing, pixel assembly and image pixel counting.
// Holds the configuration registers. Depends on tga_rle_pkg.
`timescale 1ns / 1ps

module tga_rle_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept_i,
  input  logic [tga_rle_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic                                cfg_we_i,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                                tok_valid_o,
  output tga_rle_pkg::token_t                 tok_o
);

  logic                               expect_header_r, expect_header_nxt;
  logic                               run_packet_r, run_packet_nxt;
  logic [tga_rle_pkg::COUNT_W-1:0]    left_r, left_nxt;
  logic [1:0]                         byte_idx_r, byte_idx_nxt;
  logic [tga_rle_pkg::PIXEL_W-1:0]    asm_r, asm_nxt;
  logic [tga_rle_pkg::TOTAL_W-1:0]    decoded_r, decoded_nxt;
  logic [tga_rle_pkg::BPP_W-1:0]      bpp_r;
  logic [tga_rle_pkg::TOTAL_W-1:0]    total_r;

  logic [tga_rle_pkg::BPP_W-1:0]      bpp_eff;
  logic                               last_byte;
  logic [tga_rle_pkg::PIXEL_W-1:0]    assembled;
  logic [tga_rle_pkg::TOTAL_W-1:0]    total_eff;
  logic [tga_rle_pkg::TOTAL_W-1:0]    remaining;
  logic [tga_rle_pkg::COUNT_W-1:0]    want;
  logic [tga_rle_pkg::COUNT_W-1:0]    count;
  logic [tga_rle_pkg::TOTAL_W:0]      sum;
  logic [tga_rle_pkg::COUNT_W-1:0]    left_after;
  logic                               done;
  logic                               over;
  logic                               pixel_end;

  always_comb begin
    if (bpp_r == '0) begin
      bpp_eff = 3'd1;
    end else if (bpp_r > tga_rle_pkg::BPP_MAX) begin
      bpp_eff = tga_rle_pkg::BPP_MAX;
    end else begin
      bpp_eff = bpp_r;
    end
  end

  assign last_byte = ({1'b0, byte_idx_r} + 3'd1) >= bpp_eff;

  // first byte of a pixel clears the assembly word
  assign assembled = (byte_idx_r == 2'd0) ? {24'd0, data_byte_i}
                   : (asm_r | ({24'd0, data_byte_i} << {byte_idx_r, 3'b000}));

  assign total_eff = (total_r == '0) ? 25'd1 : total_r;
  assign remaining = (total_eff > decoded_r) ? (total_eff - decoded_r) : 25'd1;

  always_comb begin
    want = run_packet_r ? left_r : 8'd1;
    if (want == '0) begin
      want = 8'd1;
    end
  end

  // remaining fits in 8 bits whenever it is the smaller one
  assign count = ({17'd0, want} < remaining) ? want : remaining[tga_rle_pkg::COUNT_W-1:0];
  assign sum   = {1'b0, decoded_r} + {18'd0, count};
  assign done  = ({17'd0, count} == remaining);
  assign over  = run_packet_r ? ({17'd0, want} > remaining) : (done && (left_r > 8'd1));
  assign left_after = (left_r > want) ? (left_r - want) : 8'd0;

  assign pixel_end = accept_i && !expect_header_r && last_byte;

  always_comb begin
    expect_header_nxt = expect_header_r;
    run_packet_nxt    = run_packet_r;
    left_nxt          = left_r;
    byte_idx_nxt      = byte_idx_r;
    asm_nxt           = asm_r;
    decoded_nxt       = decoded_r;
    if (accept_i) begin
      if (expect_header_r) begin
        run_packet_nxt    = data_byte_i[tga_rle_pkg::RUN_BIT];
        left_nxt          = {1'b0, data_byte_i[6:0]} + 8'd1;
        byte_idx_nxt      = 2'd0;
        expect_header_nxt = 1'b0;
      end else if (!last_byte) begin
        asm_nxt      = assembled;
        byte_idx_nxt = byte_idx_r + 2'd1;
      end else begin
        asm_nxt      = assembled;
        byte_idx_nxt = 2'd0;
        if (done) begin
          decoded_nxt       = '0;
          left_nxt          = '0;
          expect_header_nxt = 1'b1;
        end else begin
          decoded_nxt = sum[tga_rle_pkg::TOTAL_W-1:0];
          left_nxt    = left_after;
          if (left_after == '0) begin
            expect_header_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      run_packet_r    <= 1'b0;
      left_r          <= '0;
      byte_idx_r      <= '0;
      decoded_r       <= '0;
      bpp_r           <= tga_rle_pkg::BPP_RESET;
      total_r         <= tga_rle_pkg::TOTAL_RESET;
    end else begin
      expect_header_r <= expect_header_nxt;
      run_packet_r    <= run_packet_nxt;
      left_r          <= left_nxt;
      byte_idx_r      <= byte_idx_nxt;
      decoded_r       <= decoded_nxt;
      if (cfg_we_i) begin
        case (cfg_index_i)
          tga_rle_pkg::CFG_BYTES_PER_PIXEL: bpp_r   <= cfg_data_i[tga_rle_pkg::BPP_W-1:0];
          tga_rle_pkg::CFG_PIXEL_TOTAL:     total_r <= cfg_data_i[tga_rle_pkg::TOTAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

  assign tok_valid_o        = pixel_end;
  assign tok_o.pixel_value  = assembled;
  assign tok_o.repeat_count = count;
  assign tok_o.image_done   = done;
  assign tok_o.overrun      = over;

endmodule

// ===== hdl/tga_rle_queue.sv =====
// Back end: short token queue that presents finished words to the consumer.
// Depends on tga_rle_pkg and tga_rle_packet_decoder_assert.svh.
`timescale 1ns / 1ps
`include "tga_rle_packet_decoder_assert.svh"

module tga_rle_queue #(
  parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  tga_rle_pkg::token_t tok_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output tga_rle_pkg::token_t head_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tga_rle_pkg::token_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= tok_i;
    end
  end

  `TGA_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `TGA_ASSERT_IMPL(a_no_push_full, push_i, !full_o)
  `TGA_ASSERT_NEXT(a_push_shows, push_i && empty_o, !empty_o)
  `TGA_ASSERT_NEXT(a_hold_idle, !push_i && !pop_i, $stable(cnt_r) && $stable(rd_ptr_r))

endmodule
